// File: rtl/lpcc_pkg.sv
package lpcc_pkg;

	localparam int PageLengthDef = 66;

	localparam int RowW   = 7;
	localparam int WaitW  = 16;
	localparam int StatW  = 16;
	localparam int TapeW  = 12;
	localparam int FuncW  = 3;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;

	// command codes
	localparam logic [FuncW-1:0] FUNC_PRINT = 3'd0;
	localparam logic [FuncW-1:0] FUNC_SPACE = 3'd1;
	localparam logic [FuncW-1:0] FUNC_SKIP  = 3'd2;
	localparam logic [FuncW-1:0] FUNC_SENSE = 3'd3;
	localparam logic [FuncW-1:0] FUNC_TICK  = 3'd4;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_ONLINE    = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_XFER_WAIT = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_FAST_WAIT = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_TOP_ROW   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_BOT_ROW   = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_BOT_EN    = 3'd5;

	// status word bits
	localparam logic [StatW-1:0] ST_PARITY     = 16'h8000;
	localparam logic [StatW-1:0] ST_XFER_DONE  = 16'h4000;
	localparam logic [StatW-1:0] ST_PRINT_DONE = 16'h2000;
	localparam logic [StatW-1:0] ST_CARR_DONE  = 16'h1000;
	localparam logic [StatW-1:0] ST_RING       = 16'h0400;
	localparam logic [StatW-1:0] ST_SYNC       = 16'h0200;
	localparam logic [StatW-1:0] ST_CH9        = 16'h0010;
	localparam logic [StatW-1:0] ST_CH12       = 16'h0008;
	localparam logic [StatW-1:0] ST_CARR_BUSY  = 16'h0004;
	localparam logic [StatW-1:0] ST_PRT_BUSY   = 16'h0002;
	localparam logic [StatW-1:0] ST_NOT_READY  = 16'h0001;
	localparam logic [StatW-1:0] ST_CLEAR_MASK = ST_PARITY | ST_XFER_DONE | ST_PRINT_DONE |
		ST_CARR_DONE | ST_RING | ST_SYNC;

	// carriage tape channels
	localparam logic [TapeW-1:0] TAPE_CH1  = 12'h800;
	localparam logic [TapeW-1:0] TAPE_CH9  = 12'h008;
	localparam logic [TapeW-1:0] TAPE_CH12 = 12'h001;

	// action flag positions
	localparam int ACT_XFER  = 0;
	localparam int ACT_PRINT = 1;
	localparam int ACT_SKIP  = 2;
	localparam int ACT_SPACE = 3;

	localparam logic [WaitW-1:0] XferWaitRst = 16'd50;
	localparam logic [WaitW-1:0] FastWaitRst = 16'd100;
	localparam logic [RowW-1:0]  TopRowRst   = 7'd1;
	localparam logic [RowW-1:0]  BotRowRst   = 7'd61;

	typedef struct packed {
		logic exec;
		logic skip_start;
		logic skip_step;
		logic skip_finish;
	} lpcc_cmd_t;

	typedef struct packed {
		logic skip_svc;
		logic skip_done;
		logic out_free;
	} lpcc_stat_t;

	function automatic logic [TapeW-1:0] tape_at(input logic [RowW-1:0] row,
		input logic [RowW-1:0] top, input logic [RowW-1:0] bottom, input logic bot_en);
		logic [TapeW-1:0] t;
		t = '0;
		if (row == top) t = t | TAPE_CH1;
		if (bot_en && row == bottom) t = t | TAPE_CH12;
		return t;
	endfunction

	function automatic logic [WaitW-1:0] nonzero_wait(input logic [WaitW-1:0] ticks);
		return (ticks == '0) ? WaitW'(1) : ticks;
	endfunction

	function automatic logic [StatW-1:0] chan_bits(input logic [StatW-1:0] st,
		input logic [TapeW-1:0] t);
		logic [StatW-1:0] s;
		s = st & ~(ST_CH9 | ST_CH12);
		if ((t & TAPE_CH9) != '0) s = s | ST_CH9;
		if ((t & TAPE_CH12) != '0) s = s | ST_CH12;
		return s;
	endfunction

endpackage

// File: rtl/lpcc_ctrl.sv
module lpcc_ctrl
	import lpcc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  lpcc_stat_t stat,
	output lpcc_cmd_t  cmd
);

	typedef enum logic [0:0] {
		S_IDLE,
		S_SKIP
	} state_t;

	state_t state_q;
	logic   take;

	assign in_stall = !(state_q == S_IDLE && stat.out_free);
	assign take     = in_valid && !in_stall;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.exec       = take && !stat.skip_svc;
				cmd.skip_start = take && stat.skip_svc;
			end
			S_SKIP: begin
				cmd.skip_step   = !stat.skip_done;
				cmd.skip_finish = stat.skip_done && stat.out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take && stat.skip_svc) state_q <= S_SKIP;
				end
				S_SKIP: begin
					if (stat.skip_done && stat.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/lpcc_dp.sv
module lpcc_dp
	import lpcc_pkg::*;
#(
	parameter int PAGE_LENGTH = PageLengthDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lpcc_cmd_t           cmd,
	output lpcc_stat_t          stat,
	input  logic [FuncW-1:0]    func,
	input  logic                clear_status,
	input  logic [TapeW-1:0]    skip_channels,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [StatW-1:0]    status_word,
	output logic                interrupt_request,
	output logic [RowW-1:0]     page_row,
	output logic [RowW-1:0]     lines_advanced,
	output logic                conflict_error,
	output logic                skip_failed
);

	localparam logic [RowW-1:0] PageLen = RowW'(PAGE_LENGTH);

	// configuration; readiness lives in the status word
	logic [WaitW-1:0]  xfer_wait_q, fast_wait_q;
	logic [RowW-1:0]   top_row_q, bot_row_q;
	logic              bot_en_q;

	// carriage state
	logic [StatW-1:0]  status_q;
	logic [3:0]        flags_q;
	logic [WaitW-1:0]  wait_cnt_q;
	logic              wait_pend_q;
	logic [RowW-1:0]   row_q;
	logic [TapeW-1:0]  target_q;
	logic              irq_q;

	// skip stepper
	logic [RowW-1:0]   lines_q;
	logic              hit_q;

	logic              out_valid_q;

	function automatic logic [RowW-1:0] next_row(input logic [RowW-1:0] r);
		logic [RowW:0] s;
		s = {1'b0, r} + (RowW+1)'(1);
		return (s >= (RowW+1)'(PAGE_LENGTH)) ? '0 : s[RowW-1:0];
	endfunction

	// combinational command outcome
	logic [3:0]       x_flags;
	logic [StatW-1:0] x_status, x_shown;
	logic [WaitW-1:0] x_cnt;
	logic             x_pend, x_irq, x_conflict;
	logic [RowW-1:0]  x_row, x_lines;
	logic [TapeW-1:0] x_target;

	always_comb begin
		x_flags    = flags_q;
		x_status   = status_q;
		x_cnt      = wait_cnt_q;
		x_pend     = wait_pend_q;
		x_irq      = irq_q;
		x_conflict = 1'b0;
		x_row      = row_q;
		x_lines    = '0;
		x_target   = target_q;
		case (func)
			FUNC_PRINT: begin
				x_flags[ACT_XFER] = 1'b1;
				x_status = x_status | ST_PRT_BUSY;
				if (!wait_pend_q) begin
					x_cnt  = nonzero_wait(xfer_wait_q);
					x_pend = 1'b1;
				end
			end
			FUNC_SPACE: begin
				if (flags_q[ACT_SKIP]) begin
					x_conflict = 1'b1;
				end else begin
					x_flags[ACT_SPACE] = 1'b1;
					x_status = x_status | ST_CARR_BUSY;
					if (!wait_pend_q) begin
						x_cnt  = nonzero_wait(fast_wait_q);
						x_pend = 1'b1;
					end
				end
			end
			FUNC_SKIP: begin
				if (flags_q[ACT_SPACE]) begin
					x_conflict = 1'b1;
				end else begin
					x_flags[ACT_SKIP] = 1'b1;
					x_target = skip_channels;
					x_status = x_status | ST_CARR_BUSY;
					if (!wait_pend_q) begin
						x_cnt  = nonzero_wait(fast_wait_q);
						x_pend = 1'b1;
					end
				end
			end
			FUNC_TICK: begin
				if (wait_pend_q) begin
					x_cnt = wait_cnt_q - WaitW'(1);
					if (x_cnt == '0) begin
						x_pend = 1'b0;
						// service; the skip branch runs through the stepper instead
						if ((status_q & ST_NOT_READY) != '0) begin
							x_flags = '0;
						end else if (flags_q[ACT_XFER]) begin
							x_flags[ACT_XFER]  = 1'b0;
							x_flags[ACT_PRINT] = 1'b1;
							x_status = x_status | ST_XFER_DONE;
							x_irq = 1'b1;
						end else if (flags_q[ACT_PRINT]) begin
							x_flags[ACT_PRINT] = 1'b0;
							x_status = (x_status & ~ST_PRT_BUSY) | ST_PRINT_DONE;
							x_irq = 1'b1;
						end else if (flags_q[ACT_SPACE] && !flags_q[ACT_SKIP]) begin
							x_row = next_row(row_q);
							x_lines = RowW'(1);
							x_flags[ACT_SPACE] = 1'b0;
							x_status = (x_status & ~ST_CARR_BUSY) | ST_CARR_DONE;
							x_irq = 1'b1;
						end
						if (x_flags != '0) begin
							x_cnt  = nonzero_wait(fast_wait_q);
							x_pend = 1'b1;
						end
						x_status = chan_bits(x_status,
							tape_at(x_row, top_row_q, bot_row_q, bot_en_q));
					end
				end
			end
			default: ;
		endcase
		x_shown = x_status;
		if (func == FUNC_SENSE) begin
			x_shown = status_q;
			if (clear_status) begin
				x_status = x_status & ~ST_CLEAR_MASK;
				x_irq = 1'b0;
			end
		end
	end

	// end of skip
	logic [3:0]       f_flags;
	logic [StatW-1:0] f_status;
	logic [RowW-1:0]  s_row;

	assign s_row    = next_row(row_q);
	assign f_flags  = flags_q & ~(4'(1) << ACT_SKIP);
	assign f_status = chan_bits((status_q & ~ST_CARR_BUSY) | ST_CARR_DONE,
		tape_at(row_q, top_row_q, bot_row_q, bot_en_q));

	assign stat.skip_svc = func == FUNC_TICK && wait_pend_q && wait_cnt_q == WaitW'(1) &&
		(status_q & ST_NOT_READY) == '0 && !flags_q[ACT_XFER] && !flags_q[ACT_PRINT] &&
		flags_q[ACT_SKIP];
	assign stat.skip_done = hit_q || lines_q == PageLen;
	assign stat.out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xfer_wait_q <= XferWaitRst;
			fast_wait_q <= FastWaitRst;
			top_row_q   <= TopRowRst;
			bot_row_q   <= BotRowRst;
			bot_en_q    <= 1'b1;
			status_q    <= ST_NOT_READY;
			flags_q     <= '0;
			wait_cnt_q  <= '0;
			wait_pend_q <= 1'b0;
			row_q       <= '0;
			target_q    <= '0;
			irq_q       <= 1'b0;
			lines_q     <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				flags_q     <= x_flags;
				status_q    <= x_status;
				wait_cnt_q  <= x_cnt;
				wait_pend_q <= x_pend;
				row_q       <= x_row;
				target_q    <= x_target;
				irq_q       <= x_irq;
			end
			if (cmd.skip_start) begin
				wait_cnt_q  <= '0;
				wait_pend_q <= 1'b0;
				lines_q     <= '0;
				hit_q       <= 1'b0;
			end
			if (cmd.skip_step) begin
				row_q   <= s_row;
				lines_q <= lines_q + RowW'(1);
				hit_q   <= tape_at(s_row, top_row_q, bot_row_q, bot_en_q) == target_q;
			end
			if (cmd.skip_finish) begin
				flags_q  <= f_flags;
				status_q <= f_status;
				irq_q    <= 1'b1;
				if (f_flags != '0) begin
					wait_cnt_q  <= nonzero_wait(fast_wait_q);
					wait_pend_q <= 1'b1;
				end
			end
			if (cmd.exec || cmd.skip_finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_ONLINE:    status_q[0] <= ~cfg_data[0];
					REG_XFER_WAIT: xfer_wait_q <= cfg_data[WaitW-1:0];
					REG_FAST_WAIT: fast_wait_q <= cfg_data[WaitW-1:0];
					REG_TOP_ROW:   top_row_q   <= cfg_data[RowW-1:0];
					REG_BOT_ROW:   bot_row_q   <= cfg_data[RowW-1:0];
					REG_BOT_EN:    bot_en_q    <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_word       <= x_shown;
			interrupt_request <= x_irq;
			page_row          <= x_row;
			lines_advanced    <= x_lines;
			conflict_error    <= x_conflict;
			skip_failed       <= 1'b0;
		end else if (cmd.skip_finish) begin
			status_word       <= f_status;
			interrupt_request <= 1'b1;
			page_row          <= row_q;
			lines_advanced    <= lines_q;
			conflict_error    <= 1'b0;
			skip_failed       <= !hit_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/line_printer_carriage_controller.sv
// Line printer carriage controller. Takes one command word per accepted input (print,
// space, skip, sense, tick) and returns exactly one result word holding the status word,
// interrupt request, page row, lines moved and error flags. Most commands finish in the
// cycle they are accepted, so the result is ready in the next cycle. A tick that ends a
// wait and services a skip runs the row stepper, which advances the carriage one row per
// cycle and moves it at most PAGE_LENGTH rows. Input is stalled while the stepper runs or
// while an unread result blocks the output register. Configuration writes must be made
// only while the block is idle.
module line_printer_carriage_controller
	import lpcc_pkg::*;
#(
	parameter int PAGE_LENGTH = PageLengthDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [FuncW-1:0]    func,
	input  logic                clear_status,
	input  logic [TapeW-1:0]    skip_channels,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [StatW-1:0]    status_word,
	output logic                interrupt_request,
	output logic [RowW-1:0]     page_row,
	output logic [RowW-1:0]     lines_advanced,
	output logic                conflict_error,
	output logic                skip_failed,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	lpcc_cmd_t  cmd;
	lpcc_stat_t stat;

	lpcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	lpcc_dp #(
		.PAGE_LENGTH(PAGE_LENGTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.func              (func),
		.clear_status      (clear_status),
		.skip_channels     (skip_channels),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.status_word       (status_word),
		.interrupt_request (interrupt_request),
		.page_row          (page_row),
		.lines_advanced    (lines_advanced),
		.conflict_error    (conflict_error),
		.skip_failed       (skip_failed)
	);

endmodule

// File: rtl/lpcc_checker.sv
module lpcc_checker
	import lpcc_pkg::*;
#(
	parameter int PAGE_LENGTH = PageLengthDef
) (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input logic [StatW-1:0]    status_word,
	input logic [RowW-1:0]     page_row,
	input logic [RowW-1:0]     lines_advanced,
	input logic                conflict_error,
	input logic                skip_failed
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status_word) && $stable(page_row))
		else $error("stalled result word changed");

	// row stays on the page
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> page_row < RowW'(PAGE_LENGTH))
		else $error("page row beyond page length");

	// failed skip moves exactly one full page
	a_skip_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && skip_failed |-> lines_advanced == RowW'(PAGE_LENGTH) &&
		!conflict_error && (status_word & ST_CARR_DONE) != '0)
		else $error("failed skip did not move one page");

	// refused command moves no paper
	a_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && conflict_error |-> lines_advanced == '0 && !skip_failed)
		else $error("conflict with paper motion");

endmodule

bind line_printer_carriage_controller lpcc_checker #(.PAGE_LENGTH(PAGE_LENGTH)) u_checker (.*);
